>>> rtl/oaid_pkg.sv
package oaid_pkg;

    // list geometry
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    // operation selector
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_READ   = 2'd2
    } t_func;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_DEL_CMP,
        S_DEL_SHIFT,
        S_RD_DATA,
        S_FINISH
    } t_state;

    // datapath operations, one per cycle
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_ACCEPT,
        DP_INS_SHIFT,
        DP_INS_WRITE,
        DP_DEL_CMP,
        DP_DEL_SHIFT,
        DP_RD_DATA,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status err;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_gt;
        logic pos_eq;
        logic ins_last;
        logic match;
        logic search_last;
        logic del_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/ordered_array_insert_delete.sv
// an error goes straight to the output, a read fetches the entry at the position,
// an insert shifts entries up from the end to the position, then writes the value,
// and a delete walks entries from the front and shifts those above a match down;
// one word at a time: a new word is taken in the cycle after the result is staged
// reset (synchronous, active low) empties the list and drops any pending output;
// entries at or beyond the count are never used, so the memory is not swept
module ordered_array_insert_delete (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_position,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [5:0]         o_count,
    output logic [4:0]         o_index,
    output logic signed [31:0] o_data
);

    oaid_pkg::t_dp_cmd  w_cmd;
    oaid_pkg::t_dp_stat w_stat;

    // sequencer
    oaid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    // entry store, pointers and output register
    oaid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_position (i_position),
        .i_ready    (i_ready),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_index    (o_index),
        .o_data     (o_data)
    );

endmodule

>>> rtl/oaid_ctrl.sv
module oaid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_func,
    input  oaid_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output oaid_pkg::t_dp_cmd o_cmd
);

    oaid_pkg::t_state r_state;
    oaid_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oaid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = oaid_pkg::DP_IDLE;
        o_cmd.err   = oaid_pkg::ST_OK;
        o_ready     = 1'b0;
        unique case (r_state)
            oaid_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = oaid_pkg::DP_ACCEPT;
                    unique case (oaid_pkg::t_func'(i_func))
                        oaid_pkg::FN_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.err = oaid_pkg::ST_OVERFLOW;
                                n_state   = oaid_pkg::S_FINISH;
                            end else if (i_stat.pos_gt) begin
                                o_cmd.err = oaid_pkg::ST_BAD_POS;
                                n_state   = oaid_pkg::S_FINISH;
                            end else if (i_stat.pos_eq) begin
                                n_state = oaid_pkg::S_INS_WRITE;
                            end else begin
                                n_state = oaid_pkg::S_INS_SHIFT;
                            end
                        end
                        oaid_pkg::FN_DELETE: begin
                            if (i_stat.empty) begin
                                o_cmd.err = oaid_pkg::ST_EMPTY;
                                n_state   = oaid_pkg::S_FINISH;
                            end else begin
                                n_state = oaid_pkg::S_DEL_CMP;
                            end
                        end
                        oaid_pkg::FN_READ: begin
                            if (i_stat.pos_gt || i_stat.pos_eq) begin
                                o_cmd.err = oaid_pkg::ST_BAD_POS;
                                n_state   = oaid_pkg::S_FINISH;
                            end else begin
                                n_state = oaid_pkg::S_RD_DATA;
                            end
                        end
                        default: begin
                            o_cmd.err = oaid_pkg::ST_BAD_POS;
                            n_state   = oaid_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            oaid_pkg::S_INS_SHIFT: begin
                o_cmd.op = oaid_pkg::DP_INS_SHIFT;
                if (i_stat.ins_last) begin
                    n_state = oaid_pkg::S_INS_WRITE;
                end
            end
            oaid_pkg::S_INS_WRITE: begin
                o_cmd.op = oaid_pkg::DP_INS_WRITE;
                n_state  = oaid_pkg::S_FINISH;
            end
            oaid_pkg::S_DEL_CMP: begin
                o_cmd.op = oaid_pkg::DP_DEL_CMP;
                if (i_stat.search_last) begin
                    n_state = oaid_pkg::S_FINISH;
                end else if (i_stat.match) begin
                    n_state = oaid_pkg::S_DEL_SHIFT;
                end
            end
            oaid_pkg::S_DEL_SHIFT: begin
                o_cmd.op = oaid_pkg::DP_DEL_SHIFT;
                if (i_stat.del_last) begin
                    n_state = oaid_pkg::S_FINISH;
                end
            end
            oaid_pkg::S_RD_DATA: begin
                o_cmd.op = oaid_pkg::DP_RD_DATA;
                n_state  = oaid_pkg::S_FINISH;
            end
            oaid_pkg::S_FINISH: begin
                o_cmd.op = oaid_pkg::DP_FINISH;
                if (i_stat.out_free) begin
                    n_state = oaid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oaid_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/oaid_dp.sv
module oaid_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  oaid_pkg::t_dp_cmd                   i_cmd,
    input  logic [1:0]                          i_func,
    input  logic signed [oaid_pkg::DATA_W-1:0]  i_value,
    input  logic [5:0]                          i_position,
    input  logic                                i_ready,
    output oaid_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    output logic [2:0]                          o_status,
    output logic [5:0]                          o_count,
    output logic [4:0]                          o_index,
    output logic signed [oaid_pkg::DATA_W-1:0]  o_data
);

    localparam int AW = oaid_pkg::ADDR_W;
    localparam int CW = oaid_pkg::CNT_W;
    localparam int DW = oaid_pkg::DATA_W;

    // entry store, single write and single registered read port
    logic [DW-1:0] mem [oaid_pkg::CAPACITY];
    logic [DW-1:0] r_rdata;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_pos;
    logic signed [DW-1:0] r_val;

    // result staging and output word
    oaid_pkg::t_status    r_res_status;
    logic [AW-1:0]        r_res_index;
    logic signed [DW-1:0] r_res_data;
    logic                 r_o_valid;
    oaid_pkg::t_status    r_o_status;
    logic [CW-1:0]        r_o_count;
    logic [AW-1:0]        r_o_index;
    logic signed [DW-1:0] r_o_data;

    logic [CW-1:0] w_ptr_p1;
    logic [CW-1:0] w_ptr_p2;
    logic [CW-1:0] w_ptr_m2;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_pos_in;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_wa;
    logic [DW-1:0] w_wd;
    logic          w_we;

    assign w_ptr_p1 = r_ptr + CW'(1);
    assign w_ptr_p2 = r_ptr + CW'(2);
    assign w_ptr_m2 = r_ptr - CW'(2);
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_pos_in = CW'(i_position);

    // status toward the controller
    always_comb begin
        o_stat.full        = (r_count == CW'(oaid_pkg::CAPACITY));
        o_stat.empty       = (r_count == '0);
        o_stat.pos_gt      = (w_pos_in > r_count);
        o_stat.pos_eq      = (w_pos_in == r_count);
        o_stat.ins_last    = (r_ptr == r_pos + CW'(1));
        o_stat.match       = (r_rdata == r_val);
        o_stat.search_last = (w_ptr_p1 == r_count);
        o_stat.del_last    = (w_ptr_p2 == r_count);
        o_stat.out_free    = !r_o_valid || i_ready;
    end

    // read address: first access of an item is issued while idle
    always_comb begin
        unique case (i_cmd.op)
            oaid_pkg::DP_IDLE, oaid_pkg::DP_ACCEPT: begin
                if (oaid_pkg::t_func'(i_func) == oaid_pkg::FN_INSERT) begin
                    w_ra = w_cnt_m1[AW-1:0];
                end else if (oaid_pkg::t_func'(i_func) == oaid_pkg::FN_DELETE) begin
                    w_ra = '0;
                end else begin
                    w_ra = i_position[AW-1:0];
                end
            end
            oaid_pkg::DP_INS_SHIFT: w_ra = w_ptr_m2[AW-1:0];
            oaid_pkg::DP_DEL_CMP:   w_ra = w_ptr_p1[AW-1:0];
            oaid_pkg::DP_DEL_SHIFT: w_ra = w_ptr_p2[AW-1:0];
            default:                w_ra = r_ptr[AW-1:0];
        endcase
    end

    // write port
    always_comb begin
        w_we = 1'b0;
        w_wa = r_ptr[AW-1:0];
        w_wd = r_rdata;
        unique case (i_cmd.op)
            oaid_pkg::DP_INS_SHIFT, oaid_pkg::DP_DEL_SHIFT: begin
                w_we = 1'b1;
            end
            oaid_pkg::DP_INS_WRITE: begin
                w_we = 1'b1;
                w_wa = r_pos[AW-1:0];
                w_wd = r_val;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[w_ra];
    end

    // count and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            unique case (i_cmd.op)
                oaid_pkg::DP_ACCEPT: begin
                    if (oaid_pkg::t_func'(i_func) == oaid_pkg::FN_INSERT) begin
                        r_ptr <= r_count;
                    end else begin
                        r_ptr <= '0;
                    end
                end
                oaid_pkg::DP_INS_SHIFT: begin
                    r_ptr <= r_ptr - CW'(1);
                end
                oaid_pkg::DP_INS_WRITE: begin
                    r_count <= r_count + CW'(1);
                end
                oaid_pkg::DP_DEL_CMP: begin
                    if (o_stat.match && o_stat.search_last) begin
                        r_count <= w_cnt_m1;
                    end else if (!o_stat.match) begin
                        r_ptr <= w_ptr_p1;
                    end
                end
                oaid_pkg::DP_DEL_SHIFT: begin
                    r_ptr <= w_ptr_p1;
                    if (o_stat.del_last) begin
                        r_count <= w_cnt_m1;
                    end
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    // item operands and result staging
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            oaid_pkg::DP_ACCEPT: begin
                r_val        <= i_value;
                r_pos        <= w_pos_in;
                r_res_status <= i_cmd.err;
                r_res_index  <= '0;
                r_res_data   <= '0;
            end
            oaid_pkg::DP_INS_WRITE: begin
                r_res_status <= oaid_pkg::ST_OK;
                r_res_index  <= r_pos[AW-1:0];
            end
            oaid_pkg::DP_DEL_CMP: begin
                if (o_stat.match) begin
                    r_res_status <= oaid_pkg::ST_OK;
                    r_res_index  <= r_ptr[AW-1:0];
                    r_res_data   <= r_rdata;
                end else if (o_stat.search_last) begin
                    r_res_status <= oaid_pkg::ST_NOT_FOUND;
                end
            end
            oaid_pkg::DP_RD_DATA: begin
                r_res_status <= oaid_pkg::ST_OK;
                r_res_index  <= r_pos[AW-1:0];
                r_res_data   <= r_rdata;
            end
            default: begin
                r_res_status <= r_res_status;
            end
        endcase
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == oaid_pkg::DP_FINISH && o_stat.out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == oaid_pkg::DP_FINISH && o_stat.out_free) begin
            r_o_status <= r_res_status;
            r_o_count  <= r_count;
            r_o_index  <= r_res_index;
            r_o_data   <= r_res_data;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_count  = r_o_count;
    assign o_index  = r_o_index;
    assign o_data   = r_o_data;

endmodule

>>> rtl/oaid_checker.sv
module oaid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [1:0]         i_func,
    input logic signed [31:0] i_value,
    input logic [5:0]         i_position,
    input logic               o_valid,
    input logic               i_ready,
    input logic [2:0]         o_status,
    input logic [5:0]         o_count,
    input logic [4:0]         o_index,
    input logic signed [31:0] o_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_status))
        else $error("output word changed while stalled");

    // one word at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a word is in work");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= 6'd32)
        else $error("count beyond capacity");

    // errors carry zero index and data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != oaid_pkg::ST_OK |-> o_index == '0 && o_data == '0)
        else $error("error result with nonzero index or data");

    // overflow only when full
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == oaid_pkg::ST_OVERFLOW |-> o_count == 6'd32)
        else $error("overflow reported below capacity");

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (.*);
